// ===== hdl/gwtc_pkg.sv =====
// gwtc_pkg: shared constants, types and tables of the gps week / time of week converter.
// No dependencies; imported by every module of the block.
package gwtc_pkg;

	// field widths
	localparam int FRAC_BITS     = 16;
	localparam int SEC_W         = 25;
	localparam int TOW_BITS      = SEC_W + FRAC_BITS;
	localparam int WEEK_BITS_DEF = 14;
	localparam int YEAR_W        = 12;
	localparam int MONTH_W       = 4;
	localparam int DAY_W         = 5;
	localparam int HOUR_W        = 5;
	localparam int MIN_W         = 6;
	localparam int SEC_OUT_W     = 6;

	// pipeline depth
	localparam int NSTG = 14;

	// time constants
	localparam int SEC_DAY  = 86400;
	localparam int SEC_WEEK = 604800;
	localparam int SEC_HOUR = 3600;
	localparam int SEC_MIN  = 60;

	// bias that keeps the shifted seconds of week non-negative
	localparam int DAY_BIAS = 195;
	localparam int T_BIAS   = DAY_BIAS * SEC_DAY;
	localparam int T_W      = 26;
	localparam int Q_W      = 9;
	localparam int QMAX     = 389;
	localparam int R_W      = 18;
	localparam int SOD_W    = 17;

	// day count from gps epoch to days since 0000-03-01, less the bias
	localparam int Z_OFF = 3657 + 719468 - DAY_BIAS;
	localparam int DPE   = 146097;
	localparam int DOE_W = 18;

	// reciprocals: floor(2**k / divisor), quotient off by at most one
	localparam int RCP_DAY   = 776;
	localparam int RCP_DAY_W = 10;
	localparam int RCP_1460  = 179;
	localparam int RCP_1460_W = 8;
	localparam int K_1460    = 18;
	localparam int RCP_365   = 718;
	localparam int RCP_365_W = 10;
	localparam int K_365     = 18;
	localparam int RCP_HR    = 36;
	localparam int RCP_HR_W  = 6;
	localparam int K_HR      = 17;
	localparam int RCP_MIN   = 68;
	localparam int RCP_MIN_W = 7;
	localparam int K_MIN     = 12;

	typedef logic [NSTG:1] stg_en_t;

	// fields that travel with an item unchanged
	typedef struct packed {
		logic [FRAC_BITS-1:0] frac;
		logic                 stat;
	} tag_t;

	// largest day count for a given week width
	function automatic int z_max(int wb);
		return ((1 << wb) - 1) * 7 + QMAX + Z_OFF;
	endfunction

	function automatic int z_bits(int wb);
		return $clog2(z_max(wb) + 1);
	endfunction

	// first day of each month, counted from march 1
	function automatic logic [8:0] month_start(logic [3:0] mp);
		logic [8:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/gwtc_day.sv =====
// gwtc_day: stages 1 to 4, absolute day count and second of day from week and time of week.
// Depends on gwtc_pkg.
module gwtc_day #(
	parameter int WEEK_BITS = gwtc_pkg::WEEK_BITS_DEF
) (
	input  logic                                         clk,
	input  gwtc_pkg::stg_en_t                            stg_en,
	input  logic [WEEK_BITS-1:0]                         week_number,
	input  logic signed [gwtc_pkg::TOW_BITS-1:0]         time_of_week,
	output logic [gwtc_pkg::z_bits(WEEK_BITS)-1:0]       z_s4,
	output logic [gwtc_pkg::SOD_W-1:0]                   sod_s4,
	output gwtc_pkg::tag_t                               tag_s4
);
	import gwtc_pkg::*;

	localparam int ZW = z_bits(WEEK_BITS);
	localparam int BW = WEEK_BITS + 3;
	localparam int PW = T_W + RCP_DAY_W;

	logic [SEC_W-1:0] tow_sec;
	logic [T_W:0]     t_ext;
	logic             stat_c;

	logic [BW-1:0]    base_s1, base_s2, base_s3;
	logic [T_W-1:0]   t_s1, t_s2;
	tag_t             tag_s1, tag_s2, tag_s3;
	logic [PW-1:0]    prod_s2;
	logic [Q_W-1:0]   q0_s3;
	logic [R_W-1:0]   r0_s3;
	logic [T_W-1:0]   r0_full;
	logic [Q_W-1:0]   q_c;
	logic [R_W-1:0]   sod_c;

	function automatic logic [Q_W-1:0] q0_full();
		return prod_s2[T_W+Q_W-1:T_W];
	endfunction

	// floor seconds, biased to stay positive, and the out-of-week flag
	always_comb begin
		tow_sec = time_of_week[TOW_BITS-1:FRAC_BITS];
		t_ext   = {{(T_W + 1 - SEC_W){tow_sec[SEC_W-1]}}, tow_sec} + (T_W + 1)'(T_BIAS);
		stat_c  = tow_sec[SEC_W-1] |
			(tow_sec[SEC_W-2:0] >= (SEC_W - 1)'(SEC_WEEK));
	end

	// remainder after the estimated quotient
	always_comb begin
		r0_full = t_s2 - T_W'(q0_full()) * T_W'(SEC_DAY);
	end

	// one correction step of the quotient by 86400
	always_comb begin
		if (r0_s3 >= R_W'(SEC_DAY)) begin
			q_c   = q0_s3 + Q_W'(1);
			sod_c = r0_s3 - R_W'(SEC_DAY);
		end else begin
			q_c   = q0_s3;
			sod_c = r0_s3;
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			base_s1     <= BW'(week_number) * BW'(7);
			t_s1        <= t_ext[T_W-1:0];
			tag_s1.frac <= time_of_week[FRAC_BITS-1:0];
			tag_s1.stat <= stat_c;
		end
		if (stg_en[2]) begin
			base_s2 <= base_s1;
			t_s2    <= t_s1;
			prod_s2 <= PW'(t_s1) * PW'(RCP_DAY);
			tag_s2  <= tag_s1;
		end
		if (stg_en[3]) begin
			base_s3 <= base_s2;
			q0_s3   <= q0_full();
			r0_s3   <= r0_full[R_W-1:0];
			tag_s3  <= tag_s2;
		end
		if (stg_en[4]) begin
			z_s4   <= ZW'(base_s3) + ZW'(q_c) + ZW'(Z_OFF);
			sod_s4 <= sod_c[SOD_W-1:0];
			tag_s4 <= tag_s3;
		end
	end

endmodule

// ===== hdl/gwtc_civil.sv =====
// gwtc_civil: stages 5 to 14, day count since 0000-03-01 to gregorian year, month and day.
// Depends on gwtc_pkg.
module gwtc_civil #(
	parameter int WEEK_BITS = gwtc_pkg::WEEK_BITS_DEF
) (
	input  logic                                   clk,
	input  gwtc_pkg::stg_en_t                      stg_en,
	input  logic [gwtc_pkg::z_bits(WEEK_BITS)-1:0] z_s4,
	output logic [gwtc_pkg::YEAR_W-1:0]            year_s14,
	output logic [gwtc_pkg::MONTH_W-1:0]           month_s14,
	output logic [gwtc_pkg::DAY_W-1:0]             day_s14
);
	import gwtc_pkg::*;

	localparam int ZW      = z_bits(WEEK_BITS);
	localparam int ERA_MAX = z_max(WEEK_BITS) / DPE;
	localparam int EW      = $clog2(ERA_MAX + 1);
	localparam int P1_W    = DOE_W + RCP_1460_W;
	localparam int P2_W    = DOE_W + RCP_365_W;
	localparam int A_W     = 8;
	localparam int YOE_W   = 9;
	localparam int DOY_W   = 9;

	logic [EW-1:0]    era_c;
	logic [DOE_W-1:0] doe_c;
	logic [2:0]       b_c;
	logic [A_W-1:0]   a0_c;
	logic [DOE_W-1:0] r1_full;
	logic [A_W-1:0]   a_c;
	logic [YOE_W-1:0] y0_c;
	logic [DOE_W-1:0] r2_full;
	logic [1:0]       y100_c;
	logic [DOE_W-1:0] doy_full;
	logic [3:0]       mp_c;
	logic [3:0]       m_c;
	logic [DOY_W-1:0] d_full;

	logic [EW-1:0]    era_s5, era_s6, era_s7, era_s8, era_s9, era_s10, era_s11;
	logic [DOE_W-1:0] doe_s5, doe_s6, doe_s7, doe_s8, doe_s9, doe_s10, doe_s11;
	logic [P1_W-1:0]  p1_s6;
	logic [2:0]       b_s6, b_s7;
	logic             c_s6, c_s7;
	logic [A_W-1:0]   a0_s7;
	logic [11:0]      r1_s7;
	logic [DOE_W-1:0] n_s8, n_s9;
	logic [P2_W-1:0]  p2_s9;
	logic [YOE_W-1:0] y0_s10;
	logic [9:0]       r2_s10;
	logic [YOE_W-1:0] yoe_s11;
	logic [DOY_W-1:0] doy_s12, doy_s13;
	logic [YEAR_W-1:0] yr_s12, yr_s13;
	logic [3:0]       mp_s13;

	// 400-year era and day of era
	always_comb begin
		era_c = '0;
		doe_c = z_s4[DOE_W-1:0];
		for (int k = 1; k <= ERA_MAX; k++) begin
			if (z_s4 >= ZW'(k * DPE)) begin
				era_c = EW'(k);
				doe_c = DOE_W'(z_s4 - ZW'(k * DPE));
			end
		end
	end

	// century count within the era
	always_comb begin
		b_c = 3'd0;
		for (int k = 1; k <= 4; k++) begin
			if (doe_s5 >= DOE_W'(k * 36524)) begin
				b_c = 3'(k);
			end
		end
	end

	// day of era over 1460, estimate and remainder
	always_comb begin
		a0_c    = p1_s6[K_1460+A_W-1:K_1460];
		r1_full = doe_s6 - DOE_W'(a0_c) * DOE_W'(1460);
		a_c     = a0_s7 + ((r1_s7 >= 12'd1460) ? A_W'(1) : A_W'(0));
	end

	// year of era over 365, estimate and remainder
	always_comb begin
		y0_c    = p2_s9[K_365+YOE_W-1:K_365];
		r2_full = n_s9 - DOE_W'(y0_c) * DOE_W'(365);
	end

	// day of year from march 1
	always_comb begin
		y100_c = 2'd0;
		for (int k = 1; k <= 3; k++) begin
			if (yoe_s11 >= YOE_W'(k * 100)) begin
				y100_c = 2'(k);
			end
		end
		doy_full = doe_s11 - (DOE_W'(yoe_s11) * DOE_W'(365) + DOE_W'(yoe_s11 >> 2)
			- DOE_W'(y100_c));
	end

	// month index from march
	always_comb begin
		mp_c = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s12 >= month_start(4'(k))) begin
				mp_c = 4'(k);
			end
		end
	end

	// final month and day; the year roll for january and february is applied in stage 14
	always_comb begin
		m_c    = (mp_s13 < 4'd10) ? mp_s13 + 4'd3 : mp_s13 - 4'd9;
		d_full = doy_s13 - month_start(mp_s13) + DOY_W'(1);
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (stg_en[5]) begin
			era_s5 <= era_c;
			doe_s5 <= doe_c;
		end
		if (stg_en[6]) begin
			era_s6 <= era_s5;
			doe_s6 <= doe_s5;
			p1_s6  <= P1_W'(doe_s5) * P1_W'(RCP_1460);
			b_s6   <= b_c;
			c_s6   <= (doe_s5 >= DOE_W'(DPE - 1));
		end
		if (stg_en[7]) begin
			era_s7 <= era_s6;
			doe_s7 <= doe_s6;
			a0_s7  <= a0_c;
			r1_s7  <= r1_full[11:0];
			b_s7   <= b_s6;
			c_s7   <= c_s6;
		end
		if (stg_en[8]) begin
			era_s8 <= era_s7;
			doe_s8 <= doe_s7;
			n_s8   <= doe_s7 - DOE_W'(a_c) + DOE_W'(b_s7) - DOE_W'(c_s7);
		end
		if (stg_en[9]) begin
			era_s9 <= era_s8;
			doe_s9 <= doe_s8;
			n_s9   <= n_s8;
			p2_s9  <= P2_W'(n_s8) * P2_W'(RCP_365);
		end
		if (stg_en[10]) begin
			era_s10 <= era_s9;
			doe_s10 <= doe_s9;
			y0_s10  <= y0_c;
			r2_s10  <= r2_full[9:0];
		end
		if (stg_en[11]) begin
			era_s11 <= era_s10;
			doe_s11 <= doe_s10;
			yoe_s11 <= y0_s10 + ((r2_s10 >= 10'd365) ? YOE_W'(1) : YOE_W'(0));
		end
		if (stg_en[12]) begin
			doy_s12 <= doy_full[DOY_W-1:0];
			yr_s12  <= YEAR_W'(yoe_s11) + YEAR_W'(era_s11) * YEAR_W'(400);
		end
		if (stg_en[13]) begin
			doy_s13 <= doy_s12;
			yr_s13  <= yr_s12;
			mp_s13  <= mp_c;
		end
		if (stg_en[14]) begin
			month_s14 <= m_c;
			day_s14   <= d_full[DAY_W-1:0];
			year_s14  <= yr_s13 + ((m_c <= 4'd2) ? YEAR_W'(1) : YEAR_W'(0));
		end
	end

endmodule

// ===== hdl/gwtc_tod.sv =====
// gwtc_tod: stages 5 to 14, second of day to hour, minute and second, plus delay of the
// fraction and status so they leave with the date. Depends on gwtc_pkg.
module gwtc_tod (
	input  logic                            clk,
	input  gwtc_pkg::stg_en_t               stg_en,
	input  logic [gwtc_pkg::SOD_W-1:0]      sod_s4,
	input  gwtc_pkg::tag_t                  tag_s4,
	output logic [gwtc_pkg::HOUR_W-1:0]     hour_s14,
	output logic [gwtc_pkg::MIN_W-1:0]      minute_s14,
	output logic [gwtc_pkg::SEC_OUT_W-1:0]  second_s14,
	output gwtc_pkg::tag_t                  tag_s14
);
	import gwtc_pkg::*;

	localparam int PH_W = SOD_W + RCP_HR_W;
	localparam int RH_W = 12;
	localparam int PM_W = RH_W + RCP_MIN_W;

	typedef struct packed {
		logic [HOUR_W-1:0]    hour;
		logic [MIN_W-1:0]     minute;
		logic [SEC_OUT_W-1:0] second;
		tag_t                 tag;
	} tod_t;

	logic [HOUR_W-1:0]  h0_c;
	logic [SOD_W-1:0]   rh_full;
	logic [MIN_W-1:0]   mi0_c;
	logic [RH_W-1:0]    rm_full;

	logic [SOD_W-1:0]   sod_s5;
	logic [PH_W-1:0]    ph_s5;
	logic [HOUR_W-1:0]  h0_s6, hour_s7, hour_s8, hour_s9;
	logic [12:0]        r_s6;
	logic [RH_W-1:0]    rh_s7, rh_s8;
	logic [PM_W-1:0]    pm_s8;
	logic [MIN_W-1:0]   mi0_s9;
	logic [6:0]         r_s9;
	tag_t               tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;
	tod_t               tod_s10, tod_s11, tod_s12, tod_s13;

	// hour estimate and remainder
	always_comb begin
		h0_c    = ph_s5[K_HR+HOUR_W-1:K_HR];
		rh_full = sod_s5 - SOD_W'(h0_c) * SOD_W'(SEC_HOUR);
	end

	// minute estimate and remainder
	always_comb begin
		mi0_c   = pm_s8[K_MIN+MIN_W-1:K_MIN];
		rm_full = rh_s8 - RH_W'(mi0_c) * RH_W'(SEC_MIN);
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (stg_en[5]) begin
			sod_s5 <= sod_s4;
			ph_s5  <= PH_W'(sod_s4) * PH_W'(RCP_HR);
			tag_s5 <= tag_s4;
		end
		if (stg_en[6]) begin
			h0_s6  <= h0_c;
			r_s6   <= rh_full[12:0];
			tag_s6 <= tag_s5;
		end
		if (stg_en[7]) begin
			if (r_s6 >= 13'(SEC_HOUR)) begin
				hour_s7 <= h0_s6 + HOUR_W'(1);
				rh_s7   <= RH_W'(r_s6 - 13'(SEC_HOUR));
			end else begin
				hour_s7 <= h0_s6;
				rh_s7   <= r_s6[RH_W-1:0];
			end
			tag_s7 <= tag_s6;
		end
		if (stg_en[8]) begin
			hour_s8 <= hour_s7;
			rh_s8   <= rh_s7;
			pm_s8   <= PM_W'(rh_s7) * PM_W'(RCP_MIN);
			tag_s8  <= tag_s7;
		end
		if (stg_en[9]) begin
			hour_s9 <= hour_s8;
			mi0_s9  <= mi0_c;
			r_s9    <= rm_full[6:0];
			tag_s9  <= tag_s8;
		end
		if (stg_en[10]) begin
			tod_s10.hour <= hour_s9;
			if (r_s9 >= 7'(SEC_MIN)) begin
				tod_s10.minute <= mi0_s9 + MIN_W'(1);
				tod_s10.second <= SEC_OUT_W'(r_s9 - 7'(SEC_MIN));
			end else begin
				tod_s10.minute <= mi0_s9;
				tod_s10.second <= r_s9[SEC_OUT_W-1:0];
			end
			tod_s10.tag <= tag_s9;
		end
		// delay to line up with the date path
		if (stg_en[11]) begin
			tod_s11 <= tod_s10;
		end
		if (stg_en[12]) begin
			tod_s12 <= tod_s11;
		end
		if (stg_en[13]) begin
			tod_s13 <= tod_s12;
		end
		if (stg_en[14]) begin
			hour_s14   <= tod_s13.hour;
			minute_s14 <= tod_s13.minute;
			second_s14 <= tod_s13.second;
			tag_s14    <= tod_s13.tag;
		end
	end

endmodule

// ===== hdl/gps_week_tow_to_calendar.sv =====
// gps_week_tow_to_calendar: top level, pipeline control and the three datapath parts.
// Depends on gwtc_pkg, gwtc_day, gwtc_civil and gwtc_tod.
//
// Converts a gps week number and a signed time of week (16 fractional bits) into a
// gregorian date and a time of day, counted from 1980-01-06 00:00 with no leap seconds.
// Input channel: in_valid / in_ready with week_number and time_of_week.
// Output channel: out_valid / out_ready with the date, time of day, fraction and status.
// Status is 1 when the time of week is negative or at least one week; the time is still
// converted as an offset from the start of the given week.
// Throughput is one item per cycle while the output is not stalled; the 14 register
// stages are set by the chain of constant divisions (day, 400-year era, century, year,
// month, hour, minute).
// Each stage holds its own valid bit and loads whenever it is empty or the stage after
// it moves, so a stalled output only stops stages that are full; empty stages keep
// taking items until the pipeline is full, and nothing is lost or repeated.
// Reset clears the valid bits only; the block accepts an item in the first cycle after.
module gps_week_tow_to_calendar #(
	parameter int WEEK_BITS = gwtc_pkg::WEEK_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [WEEK_BITS-1:0]                 week_number,
	input  logic signed [gwtc_pkg::TOW_BITS-1:0] time_of_week,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [gwtc_pkg::YEAR_W-1:0]          cal_year,
	output logic [gwtc_pkg::MONTH_W-1:0]         cal_month,
	output logic [gwtc_pkg::DAY_W-1:0]           cal_day,
	output logic [gwtc_pkg::HOUR_W-1:0]          hour_of_day,
	output logic [gwtc_pkg::MIN_W-1:0]           minute_of_hour,
	output logic [gwtc_pkg::SEC_OUT_W-1:0]       whole_second,
	output logic [gwtc_pkg::FRAC_BITS-1:0]       second_fraction,
	output logic                                 status
);
	import gwtc_pkg::*;

	localparam int ZW = z_bits(WEEK_BITS);

	stg_en_t           stg_en;
	logic [NSTG:1]     vld_q;
	logic              in_acc;
	logic              out_acc;
	logic [ZW-1:0]     z_s4;
	logic [SOD_W-1:0]  sod_s4;
	tag_t              tag_s4;
	tag_t              tag_s14;

	// stage load enables, from the output back to the input
	always_comb begin
		stg_en[NSTG] = !vld_q[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			stg_en[k] = !vld_q[k] || stg_en[k+1];
		end
	end

	assign in_ready  = stg_en[1];
	assign out_valid = vld_q[NSTG];
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stg_en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (stg_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// day count and second of day
	gwtc_day #(
		.WEEK_BITS(WEEK_BITS)
	) u_day (
		.clk         (clk),
		.stg_en      (stg_en),
		.week_number (week_number),
		.time_of_week(time_of_week),
		.z_s4        (z_s4),
		.sod_s4      (sod_s4),
		.tag_s4      (tag_s4)
	);

	// calendar date
	gwtc_civil #(
		.WEEK_BITS(WEEK_BITS)
	) u_civil (
		.clk      (clk),
		.stg_en   (stg_en),
		.z_s4     (z_s4),
		.year_s14 (cal_year),
		.month_s14(cal_month),
		.day_s14  (cal_day)
	);

	// time of day
	gwtc_tod u_tod (
		.clk       (clk),
		.stg_en    (stg_en),
		.sod_s4    (sod_s4),
		.tag_s4    (tag_s4),
		.hour_s14  (hour_of_day),
		.minute_s14(minute_of_hour),
		.second_s14(whole_second),
		.tag_s14   (tag_s14)
	);

	assign second_fraction = tag_s14.frac;
	assign status          = tag_s14.stat;

	// an empty output stage never holds off the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	// items in flight change only by what is accepted and delivered
	a_item_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_q) == $countones($past(vld_q))
			+ int'($past(in_acc)) - int'($past(out_acc))))
		else $error("item lost or duplicated in the pipeline");

	// a delivered result has month 1 to 12, day at least 1 and a legal time of day
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1 &&
			hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 && whole_second <= 6'd59))
		else $error("result field out of range");

endmodule
